[hdl/kot_pkg.sv]
package kot_pkg;

    // Table size and key width.
    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 64;

    // Derived widths: an index addresses one entry, a count holds zero to CAPACITY.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Mask that keeps the low KEY_BITS bits of an incoming key.
    localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << KEY_BITS) - 64'd1);

    // Command codes.
    typedef enum logic [1:0] {
        CMD_UPSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_AT     = 2'd3
    } t_cmd;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_CAPACITY  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Control states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_SHIFT,
        S_DONE
    } t_state;

    // One stored entry, kept in a single memory word.
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] payload;
        logic [63:0] rev;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[hdl/kot_ram.sv]
module kot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/keyed_ordered_table_core.sv]
// Keyed ordered table: up to CAPACITY entries (key, payload, revision) kept in
// insertion order in one single-port-read, single-port-write memory.
// Input channel: i_in_valid / o_in_stall carries one word with a command
// (upsert, remove, find by key, read at position) and its key, payload and
// position. Output channel: o_out_valid / i_out_stall returns one result word
// per command with status, the found entry, the entry count and table revision.
// The block works on one command at a time. A key search reads one entry per
// cycle through the memory's registered read port; a remove then moves each
// later entry down one position at one entry per cycle, so search and
// compaction together pass over each entry once. A rejected upsert or an
// out-of-range read goes straight to the done state, a read at position
// passes through the read state, find and upsert run a search, and remove
// runs a search and then compaction. The next word is accepted in the cycle
// after the result is registered, even if it has not been taken yet.
// A finished result waits in the output register while i_out_stall is high;
// the block then holds a completed command until that register frees up.
// Synchronous reset empties the table and sets the revision to one; the
// memory contents are not cleared since entries at or above the count are
// never read.
module keyed_ordered_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  kot_pkg::t_cmd         i_cmd,
    input  logic [63:0]           i_key_in,
    input  logic [63:0]           i_payload_in,
    input  logic [4:0]            i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output kot_pkg::t_status      o_status,
    output logic [63:0]           o_out_key,
    output logic [63:0]           o_out_payload,
    output logic [63:0]           o_out_entry_rev,
    output logic [5:0]            o_entry_count,
    output logic [63:0]           o_table_rev
);
    import kot_pkg::*;

    // Control registers.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [63:0]       r_rev, n_rev;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    // Working registers for the current command.
    t_cmd              r_cmd, n_cmd;
    logic [63:0]       r_key, n_key;
    logic [63:0]       r_payload, n_payload;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;

    // Result being built.
    t_status           r_res_status, n_res_status;
    t_entry            r_res, n_res;

    // Output registers.
    t_status           r_out_status, n_out_status;
    t_entry            r_out, n_out;
    logic [5:0]        r_out_count, n_out_count;
    logic [63:0]       r_out_rev, n_out_rev;

    // Memory port signals.
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    // Shared decode.
    logic              in_accept;
    logic              out_free;
    logic [63:0]       key_masked;
    logic              slot_ok;
    logic              cmp_hit;
    logic              search_miss;
    logic              shift_end;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign key_masked  = i_key_in & KEY_MASK;
    assign slot_ok     = ({27'd0, i_slot_index} < 32'(r_fill)) &&
                         ({27'd0, i_slot_index} < 32'(CAPACITY));
    assign cmp_hit     = r_pend && (rd_data.key == r_key);
    assign search_miss = !cmp_hit && (r_idx >= r_fill);
    assign shift_end   = !r_pend && (r_idx >= r_fill);

    kot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_cmd == CMD_UPSERT && key_masked == 64'd0) begin
                        n_state = S_DONE;
                    end else if (i_cmd == CMD_AT) begin
                        n_state = slot_ok ? S_READ : S_DONE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (cmp_hit) begin
                    n_state = (r_cmd == CMD_REMOVE) ? S_SHIFT : S_DONE;
                end else if (search_miss) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SHIFT: begin
                if (shift_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_fill       = r_fill;
        n_rev        = r_rev;
        n_pend       = r_pend;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_payload    = r_payload;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res        = r_res;
        rd_en        = 1'b0;
        rd_addr      = r_idx[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = '{key: r_key, payload: r_payload, rev: r_rev + 64'd1};
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd        = i_cmd;
                    n_key        = key_masked;
                    n_payload    = i_payload_in;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_res_status = ST_OK;
                    n_res        = '0;
                    if (i_cmd == CMD_UPSERT && key_masked == 64'd0) begin
                        n_res_status = ST_INVALID;
                    end else if (i_cmd == CMD_AT) begin
                        if (slot_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = i_slot_index[IDX_W-1:0];
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_SEARCH: begin
                // Issue the next read while the previous one is compared.
                if (!cmp_hit && r_idx < r_fill) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    n_pos  = r_idx[IDX_W-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (cmp_hit) begin
                    case (r_cmd)
                        CMD_FIND: begin
                            n_res = rd_data;
                        end
                        CMD_UPSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos;
                            n_rev   = r_rev + 64'd1;
                        end
                        CMD_REMOVE: begin
                            // Compact: read from the hit position plus one.
                            n_idx  = CNT_W'(r_pos) + CNT_W'(1);
                            n_pos  = r_pos;
                            n_pend = 1'b0;
                        end
                        default: begin
                            n_res = r_res;
                        end
                    endcase
                end else if (search_miss) begin
                    if (r_cmd == CMD_UPSERT) begin
                        if (r_fill >= CNT_W'(CAPACITY)) begin
                            n_res_status = ST_CAPACITY;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_fill[IDX_W-1:0];
                            n_fill  = r_fill + CNT_W'(1);
                            n_rev   = r_rev + 64'd1;
                        end
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end
            end
            S_READ: begin
                n_res = rd_data;
            end
            S_SHIFT: begin
                // Write the entry read last cycle one position lower.
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = rd_data;
                    n_pos   = r_pos + IDX_W'(1);
                end
                if (r_idx < r_fill) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (shift_end) begin
                    n_fill = r_fill - CNT_W'(1);
                    n_rev  = r_rev + 64'd1;
                end
            end
            S_DONE: begin
                n_pend = 1'b0;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Output register: loaded when a command completes and the slot is free.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out        = r_out;
        n_out_count  = r_out_count;
        n_out_rev    = r_out_rev;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out        = r_res;
            n_out_count  = 6'(r_fill);
            n_out_rev    = r_rev;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rev       <= 64'd1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rev       <= n_rev;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_payload    <= n_payload;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
        r_out_rev    <= n_out_rev;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_out_key       = r_out.key;
    assign o_out_payload   = r_out.payload;
    assign o_out_entry_rev = r_out.rev;
    assign o_entry_count   = r_out_count;
    assign o_table_rev     = r_out_rev;

    // The entry count never exceeds the table capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The memory is written only during a search hit, an append or compaction.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_SEARCH || r_state == S_SHIFT))
        else $error("memory write outside search or shift");

    // The revision moves only when an upsert or remove completes.
    a_rev_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_rev)) |->
            ($past(r_state) == S_SEARCH || $past(r_state) == S_SHIFT))
        else $error("table revision changed outside a table update");

    // The count changes only together with the revision.
    a_fill_with_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_fill)) |-> !$stable(r_rev))
        else $error("entry count changed without a revision step");

endmodule
